// ===== hdl/mcsd_pkg.sv =====
// Package for the multi-chain shift-out driver.
// Request and pulse types, the controller state type and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package mcsd_pkg;

    localparam int REQ_TYPE_W   = 2;
    localparam int CHAIN_IDX_W  = 2;
    localparam int BIT_IDX_W    = 5;
    localparam int REG_IDX_W    = 2;
    localparam int BYTE_W       = 8;
    localparam int LANE_W       = 4;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_SET_BIT  = 2'd0,
        REQ_SET_BYTE = 2'd1,
        REQ_SET_ALL  = 2'd2,
        REQ_LOAD     = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LATCH
    } t_state;

    typedef struct packed {
        t_req_type              req_type;
        logic [CHAIN_IDX_W-1:0] chain_index;
        logic [BIT_IDX_W-1:0]   bit_index;
        logic [REG_IDX_W-1:0]   reg_index;
        logic [BYTE_W-1:0]      byte_value;
        logic                   bit_value;
    } t_req;

    typedef struct packed {
        logic [LANE_W-1:0] lane_bits;
        logic              is_latch;
        logic              last;
    } t_pulse;

    // controller -> datapath
    typedef struct packed {
        logic wr;     // apply the accepted write request
        logic start;  // load begins: clear the changed mark
        logic shift;  // emit one shift pulse and rotate the chains
        logic latch;  // emit the latch pulse
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dirty;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/mcsd_if.sv =====
// Valid/ready channel interfaces for the shift-out driver.
// Depends on mcsd_pkg.
`default_nettype none

interface mcsd_req_if import mcsd_pkg::*; ();
    logic valid;
    logic ready;
    t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface mcsd_pulse_if import mcsd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pulse pulse;

    modport source (output valid, output pulse, input ready);
    modport sink   (input valid, input pulse, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcsd_datapath.sv =====
// Datapath: chain image as rotating shift registers, changed mark and
// the output pulse register. Driven by mcsd_ctrl; depends on mcsd_pkg.
`default_nettype none

module mcsd_datapath import mcsd_pkg::*; #(
    parameter int NUM_CHAINS = 4,
    parameter int NUM_REGS   = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_req    i_req,
    output t_dp_sts      o_sts,
    output logic         o_pulse_valid,
    output t_pulse       o_pulse,
    input  wire logic    i_pulse_ready
);

    localparam int CHAIN_W = 8 * NUM_REGS;

    // each chain is a flat vector, byte r at [8r+7:8r]; MSB goes out first
    logic [CHAIN_W-1:0] r_chain [NUM_CHAINS];
    logic [CHAIN_W-1:0] n_chain [NUM_CHAINS];
    logic               r_dirty;
    logic               r_out_valid;
    logic [LANE_W-1:0]  r_lane_bits;
    logic               r_is_latch;
    logic [LANE_W-1:0]  w_msb_lanes;
    logic               w_chain_ok;
    logic               w_bit_reg_ok;
    logic               w_byte_reg_ok;
    logic               w_wr_hit;

    assign w_chain_ok    = int'(i_req.chain_index) < NUM_CHAINS;
    assign w_bit_reg_ok  = int'(i_req.bit_index[BIT_IDX_W-1:3]) < NUM_REGS;
    assign w_byte_reg_ok = int'(i_req.reg_index) < NUM_REGS;

    always_comb begin
        unique case (i_req.req_type)
            REQ_SET_BIT:  w_wr_hit = w_chain_ok && w_bit_reg_ok;
            REQ_SET_BYTE: w_wr_hit = w_chain_ok && w_byte_reg_ok;
            REQ_SET_ALL:  w_wr_hit = 1'b1;
            REQ_LOAD:     w_wr_hit = 1'b0;
            default:      w_wr_hit = 1'b0;
        endcase
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAINS; c++) begin
            n_chain[c] = r_chain[c];
            if (i_cmd.shift) begin
                n_chain[c] = {r_chain[c][CHAIN_W-2:0], r_chain[c][CHAIN_W-1]};
            end else if (i_cmd.wr) begin
                unique case (i_req.req_type)
                    REQ_SET_BIT: begin
                        for (int p = 0; p < CHAIN_W; p++) begin
                            if (int'(i_req.chain_index) == c && int'(i_req.bit_index) == p)
                                n_chain[c][p] = i_req.bit_value;
                        end
                    end
                    REQ_SET_BYTE: begin
                        for (int r = 0; r < NUM_REGS; r++) begin
                            if (int'(i_req.chain_index) == c && int'(i_req.reg_index) == r)
                                n_chain[c][8*r +: 8] = i_req.byte_value;
                        end
                    end
                    REQ_SET_ALL: n_chain[c] = {CHAIN_W{i_req.bit_value}};
                    REQ_LOAD:    n_chain[c] = r_chain[c];
                    default:     n_chain[c] = r_chain[c];
                endcase
            end
        end
    end

    generate
        for (genvar j = 0; j < LANE_W; j++) begin : g_lane
            if (j < NUM_CHAINS) begin : g_on
                assign w_msb_lanes[j] = r_chain[j][CHAIN_W-1];
            end else begin : g_off
                assign w_msb_lanes[j] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHAINS; c++) r_chain[c] <= '0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            for (int c = 0; c < NUM_CHAINS; c++) r_chain[c] <= n_chain[c];
            if (i_cmd.start)
                r_dirty <= 1'b0;
            else if (i_cmd.wr && w_wr_hit)
                r_dirty <= 1'b1;
            if (i_cmd.shift || i_cmd.latch)
                r_out_valid <= 1'b1;
            else if (i_pulse_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_lane_bits <= w_msb_lanes;
            r_is_latch  <= 1'b0;
        end else if (i_cmd.latch) begin
            r_lane_bits <= '0;
            r_is_latch  <= 1'b1;
        end
    end

    assign o_sts.dirty    = r_dirty;
    assign o_sts.out_free = !r_out_valid || i_pulse_ready;

    assign o_pulse_valid   = r_out_valid;
    assign o_pulse.lane_bits = r_lane_bits;
    assign o_pulse.is_latch  = r_is_latch;
    assign o_pulse.last      = r_is_latch;

    a_latch_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_is_latch |-> r_lane_bits == '0)
        else $error("latch pulse carries data bits");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> !r_dirty)
        else $error("changed mark survived a load");

    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr && w_wr_hit && !i_cmd.start |=> r_dirty)
        else $error("write did not mark image changed");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift || i_cmd.latch) |-> o_sts.out_free)
        else $error("pulse issued over an unaccepted pulse");

endmodule

`default_nettype wire

// ===== hdl/mcsd_ctrl.sv =====
// Controller FSM: request handshake, load sequencing and pulse counter.
// Drives mcsd_datapath through t_dp_cmd; depends on mcsd_pkg.
`default_nettype none

module mcsd_ctrl import mcsd_pkg::*; #(
    parameter int NUM_REGS = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_req_valid,
    input  wire t_req_type i_req_type,
    output logic           o_req_ready,
    input  wire t_dp_sts   i_sts,
    output t_dp_cmd        o_cmd
);

    localparam int                NUM_BITS = 8 * NUM_REGS;
    localparam int                CNT_W    = $clog2(NUM_BITS);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(NUM_BITS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign w_accept = i_req_valid && o_req_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        // load of an unchanged image is dropped
                        if (i_sts.dirty) begin
                            o_cmd.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = ST_SHIFT;
                        end
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_SHIFT: begin
                if (i_sts.out_free) begin
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == LAST_CNT)
                        n_state = ST_LATCH;
                end
            end
            ST_LATCH: begin
                if (i_sts.out_free) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_req_ready && !o_cmd.wr)
        else $error("request taken during a load");

    a_shift_to_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SHIFT && r_cnt == LAST_CNT && i_sts.out_free |=> r_state == ST_LATCH)
        else $error("latch does not follow the last shift");

    a_latch_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> r_state == ST_IDLE)
        else $error("load did not end after latch");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr, o_cmd.start, o_cmd.shift, o_cmd.latch}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== hdl/multi_chain_shift_out_driver.sv =====
// Channel   Dir  Modport               Payload
// i_req     in   mcsd_req_if.sink      t_req: type, chain, bit, reg, byte, bit value
// o_pulse   out  mcsd_pulse_if.source  t_pulse: lane_bits, is_latch, last
//
// A write request (set bit, set byte, set all) is applied when it is taken.
// A load of a changed image holds i_req.ready low while it issues 8*NUM_REGS shift
// pulses and one latch pulse, one per cycle through the output register while o_pulse
// is not stalled; the pulses start once the controller has moved from ST_IDLE to ST_SHIFT.
// A load of an unchanged image is taken and gives no pulse.
// A stalled o_pulse holds the sequence; reset (sync, active low) clears image.
// Top level of the multi-chain shift-out driver; depends on mcsd_pkg,
// mcsd_if, mcsd_ctrl and mcsd_datapath.
`default_nettype none

module multi_chain_shift_out_driver import mcsd_pkg::*; #(
    parameter int NUM_CHAINS = 4,
    parameter int NUM_REGS   = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mcsd_req_if.sink     i_req,
    mcsd_pulse_if.source o_pulse
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mcsd_ctrl #(
        .NUM_REGS (NUM_REGS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req.req_type),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mcsd_datapath #(
        .NUM_CHAINS (NUM_CHAINS),
        .NUM_REGS   (NUM_REGS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req         (i_req.req),
        .o_sts         (w_sts),
        .o_pulse_valid (o_pulse.valid),
        .o_pulse       (o_pulse.pulse),
        .i_pulse_ready (o_pulse.ready)
    );

endmodule

`default_nettype wire

// ===== test/multi_chain_shift_out_driver_test.sv =====
// Self-checking bench for multi_chain_shift_out_driver: directed and random requests,
// with a predicted pulse stream checked field by field under random stalls.
// Depends on mcsd_pkg, mcsd_if and the driver RTL.

module multi_chain_shift_out_driver_test;
    import mcsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHAINS  = 4;
    localparam int NUM_REGS    = 4;
    localparam int RAND_COUNT  = 410;
    localparam int CALM_TAIL   = 50;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mcsd_req_if   req_if();
    mcsd_pulse_if pulse_if();

    multi_chain_shift_out_driver #(
        .NUM_CHAINS(NUM_CHAINS),
        .NUM_REGS  (NUM_REGS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_pulse(pulse_if)
    );

    // predicted state of the chain image
    logic [7:0] chain_image [NUM_CHAINS][NUM_REGS];
    logic       image_changed;

    t_req   pending_reqs [$];
    t_pulse pulses_due [$];

    bit stimulus_built = 1'b0;
    bit req_fire = 1'b0;
    bit long_hold_done = 1'b0;
    int req_gap = 0;
    int hold_left = 0;
    int reqs_taken = 0;
    int loads_pulsed = 0;
    int pulses_checked = 0;
    int errors = 0;
    int stall_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void predict_pulses(t_req r);
        logic [LANE_W-1:0] lanes;
        t_pulse p;
        case (r.req_type)
            REQ_SET_BIT: begin
                if (r.chain_index < NUM_CHAINS && r.bit_index[4:3] < NUM_REGS) begin
                    chain_image[r.chain_index][r.bit_index[4:3]][r.bit_index[2:0]] =
                        r.bit_value;
                    image_changed = 1'b1;
                end
            end
            REQ_SET_BYTE: begin
                if (r.chain_index < NUM_CHAINS && r.reg_index < NUM_REGS) begin
                    chain_image[r.chain_index][r.reg_index] = r.byte_value;
                    image_changed = 1'b1;
                end
            end
            REQ_SET_ALL: begin
                foreach (chain_image[c, g])
                    chain_image[c][g] = {8{r.bit_value}};
                image_changed = 1'b1;
            end
            REQ_LOAD: begin
                if (image_changed) begin
                    image_changed = 1'b0;
                    loads_pulsed++;
                    for (int g = NUM_REGS - 1; g >= 0; g--) begin
                        for (int b = 7; b >= 0; b--) begin
                            lanes = '0;
                            for (int c = 0; c < NUM_CHAINS && c < LANE_W; c++)
                                lanes[c] = chain_image[c][g][b];
                            p.lane_bits = lanes;
                            p.is_latch  = 1'b0;
                            p.last      = 1'b0;
                            pulses_due.push_back(p);
                        end
                    end
                    p.lane_bits = '0;
                    p.is_latch  = 1'b1;
                    p.last      = 1'b1;
                    pulses_due.push_back(p);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(t_req_type kind, int chain, int bidx, int ridx,
                                          int value, bit fill);
        t_req r;
        r.req_type    = kind;
        r.chain_index = CHAIN_IDX_W'(chain);
        r.bit_index   = BIT_IDX_W'(bidx);
        r.reg_index   = REG_IDX_W'(ridx);
        r.byte_value  = BYTE_W'(value);
        r.bit_value   = fill;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_random(t_req_type kind);
        queue_request(kind, $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 3),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endfunction

    // sender: holds a request until taken, then maybe idles for a burst
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_if.valid <= 1'b1;
                req_if.req   <= pending_reqs.pop_front();
                if (!(stimulus_built && pending_reqs.size() < CALM_TAIL) &&
                    $urandom_range(0, 99) < 15)
                    req_gap = $urandom_range(1, 17);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold while a load is running
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pulse_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pulse_if.ready <= 1'b0;
        end else if (!long_hold_done && reqs_taken >= 150 && pulse_if.valid) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            pulse_if.ready <= 1'b0;
        end else if (!(stimulus_built && pending_reqs.size() < CALM_TAIL) &&
                     $urandom_range(0, 99) < 10) begin
            hold_left = $urandom_range(1, 17) - 1;
            pulse_if.ready <= 1'b0;
        end else begin
            pulse_if.ready <= 1'b1;
        end
    end

    // monitor: predict on each taken request, check each taken pulse
    always @(posedge i_clk) begin
        t_pulse want;
        req_fire <= req_if.valid && req_if.ready;
        if (req_if.valid && req_if.ready) begin
            predict_pulses(req_if.req);
            reqs_taken <= reqs_taken + 1;
        end
        if (pulse_if.valid && pulse_if.ready) begin
            if (pulses_due.size() == 0) begin
                $error("unexpected pulse: lane_bits=%h is_latch=%b last=%b",
                       pulse_if.pulse.lane_bits, pulse_if.pulse.is_latch,
                       pulse_if.pulse.last);
                errors++;
            end else begin
                want = pulses_due.pop_front();
                pulses_checked++;
                if (pulse_if.pulse.lane_bits !== want.lane_bits) begin
                    $error("lane_bits: expected %h, got %h", want.lane_bits,
                           pulse_if.pulse.lane_bits);
                    errors++;
                end
                if (pulse_if.pulse.is_latch !== want.is_latch) begin
                    $error("is_latch: expected %b, got %b", want.is_latch,
                           pulse_if.pulse.is_latch);
                    errors++;
                end
                if (pulse_if.pulse.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, pulse_if.pulse.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (pulse_if.valid && pulse_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int added;
        req_if.valid = 1'b0;
        req_if.req = '0;
        pulse_if.ready = 1'b0;
        foreach (chain_image[c, g])
            chain_image[c][g] = 8'h00;
        image_changed = 1'b0;

        // directed: unchanged load, fills, corner bits and bytes, repeated loads
        queue_request(REQ_LOAD, 0, 0, 0, 0, 0);
        queue_request(REQ_SET_ALL, 0, 0, 0, 0, 1);
        queue_request(REQ_LOAD, 3, 31, 3, 255, 1);
        queue_request(REQ_LOAD, 0, 0, 0, 0, 0);
        queue_request(REQ_SET_ALL, 3, 31, 3, 255, 0);
        queue_request(REQ_SET_BIT, 3, 31, 0, 0, 1);
        queue_request(REQ_SET_BIT, 0, 0, 3, 255, 1);
        queue_request(REQ_SET_BYTE, 1, 0, 3, 8'hA5, 0);
        queue_request(REQ_SET_BYTE, 2, 31, 0, 8'hFF, 1);
        queue_request(REQ_SET_BYTE, 3, 0, 0, 8'h00, 1);
        queue_request(REQ_LOAD, 0, 0, 0, 0, 0);
        queue_request(REQ_SET_BIT, 3, 31, 0, 0, 0);
        queue_request(REQ_SET_BIT, 2, 16, 2, 8'h5A, 1);
        queue_request(REQ_SET_BYTE, 0, 7, 1, 8'h5A, 0);
        queue_request(REQ_LOAD, 2, 5, 1, 8'h33, 1);
        queue_request(REQ_LOAD, 1, 9, 2, 8'hCC, 0);
        queue_request(REQ_SET_BIT, 1, 8, 1, 0, 1);
        queue_request(REQ_LOAD, 0, 0, 0, 0, 0);

        // random: mostly writes followed by a load, some raw noise
        added = 0;
        while (added < RAND_COUNT) begin
            if ($urandom_range(0, 99) < 10) begin
                queue_random(t_req_type'($urandom_range(0, 3)));
                added++;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: queue_random(REQ_SET_BIT);
                        5, 6, 7, 8:    queue_random(REQ_SET_BYTE);
                        default:       queue_random(REQ_SET_ALL);
                    endcase
                    added++;
                end
                queue_random(REQ_LOAD);
                added++;
            end
        end
        stimulus_built = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (pulses_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d requests; %0d loads sent %0d pulses, all checked.",
                 reqs_taken, loads_pulsed, pulses_checked);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
